// ===== sv/xsrd_pkg.sv =====
package xsrd_pkg;

  localparam int unsigned DEF_MAX_RECORD_BYTES = 32;
  localparam int unsigned DEF_MAX_SUBSECTIONS  = 16;

  localparam int unsigned CFG_W     = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned LEN_W     = 9;

  localparam logic [CFG_W-1:0] WIDTH_TYPE_RST   = 6'd1;
  localparam logic [CFG_W-1:0] WIDTH_SECOND_RST = 6'd3;
  localparam logic [CFG_W-1:0] WIDTH_THIRD_RST  = 6'd1;
  localparam logic [CFG_W-1:0] WIDTH_REST_RST   = 6'd0;

  localparam logic [31:0] TYPE_PLAIN  = 32'd1;
  localparam logic [31:0] TYPE_PACKED = 32'd2;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DESC  = 2'd1,
    OP_DATA  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_TYPE   = 2'd0,
    CFG_WIDTH_SECOND = 2'd1,
    CFG_WIDTH_THIRD  = 2'd2,
    CFG_WIDTH_REST   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  data_byte;
    logic [30:0] sub_start;
    logic [30:0] sub_count;
  } in_word_t;

  typedef struct packed {
    logic        entry_kind;
    logic [31:0] object_number;
    logic [31:0] second_value;
    logic [31:0] third_value;
  } out_word_t;

  typedef struct packed {
    logic [30:0] start;
    logic [30:0] count;
  } desc_t;

endpackage

// ===== sv/xsrd_desc_mem.sv =====
module xsrd_desc_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [AW-1:0]  waddr_i,
  input  xsrd_pkg::desc_t wdata_i,
  input  logic [AW-1:0]  raddr_i,
  output xsrd_pkg::desc_t rdata_o
);
  import xsrd_pkg::*;

  desc_t mem_q [DEPTH];
  desc_t rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // write-to-read forwarding for the same entry
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rd_q <= wdata_i;
    end else begin
      rd_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rd_q;

endmodule

// ===== sv/xsrd_rec_ctrl.sv =====
module xsrd_rec_ctrl #(
  parameter int unsigned MAX_RECORD_BYTES = 32,
  parameter int unsigned MAX_SUBSECTIONS  = 16,
  parameter int unsigned AW               = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [xsrd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [xsrd_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_fire_i,
  input  xsrd_pkg::in_word_t                  in_word_i,
  input  xsrd_pkg::desc_t                     desc_rd_i,
  output logic                                desc_we_o,
  output logic [AW-1:0]                       desc_waddr_o,
  output xsrd_pkg::desc_t                     desc_wdata_o,
  output logic [AW-1:0]                       desc_raddr_o,
  output logic                                out_push_o,
  output xsrd_pkg::out_word_t                 out_word_o
);
  import xsrd_pkg::*;

  localparam int unsigned PW = $clog2(MAX_RECORD_BYTES);
  localparam int unsigned CW = $clog2(MAX_SUBSECTIONS + 1);

  logic [CFG_W-1:0] width_type_q, width_second_q, width_third_q, width_rest_q;

  logic [CW-1:0] desc_loaded_q, desc_loaded_d;
  logic [CW-1:0] desc_next_q, desc_next_d;
  logic [30:0]   remaining_q, remaining_d;
  logic          past_end_q, past_end_d;
  logic [31:0]   cur_obj_q, cur_obj_d;
  logic [PW-1:0] byte_pos_q, byte_pos_d;
  logic [31:0]   type_acc_q, type_acc_d;
  logic [31:0]   second_acc_q, second_acc_d;
  logic [31:0]   third_acc_q, third_acc_d;

  logic [LEN_W-1:0] rec_len, t1, t2, t3, pos_ext, pos_nxt;
  logic             do_load;
  logic [31:0]      obj;
  logic [30:0]      rem;
  logic [31:0]      rec_type;
  logic [31:0]      sec_out, thr_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_type_q   <= WIDTH_TYPE_RST;
      width_second_q <= WIDTH_SECOND_RST;
      width_third_q  <= WIDTH_THIRD_RST;
      width_rest_q   <= WIDTH_REST_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH_TYPE:   width_type_q   <= cfg_data_i;
        CFG_WIDTH_SECOND: width_second_q <= cfg_data_i;
        CFG_WIDTH_THIRD:  width_third_q  <= cfg_data_i;
        CFG_WIDTH_REST:   width_rest_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign t1      = LEN_W'(width_type_q);
  assign t2      = t1 + LEN_W'(width_second_q);
  assign t3      = t2 + LEN_W'(width_third_q);
  assign rec_len = t3 + LEN_W'(width_rest_q);
  assign pos_ext = LEN_W'(byte_pos_q);
  assign pos_nxt = pos_ext + LEN_W'(1);

  always_comb begin
    desc_loaded_d = desc_loaded_q;
    desc_next_d   = desc_next_q;
    remaining_d   = remaining_q;
    past_end_d    = past_end_q;
    cur_obj_d     = cur_obj_q;
    byte_pos_d    = byte_pos_q;
    type_acc_d    = type_acc_q;
    second_acc_d  = second_acc_q;
    third_acc_d   = third_acc_q;
    desc_we_o     = 1'b0;
    out_push_o    = 1'b0;
    do_load       = 1'b0;
    obj           = cur_obj_q;
    rem           = remaining_q;
    rec_type      = TYPE_PLAIN;
    sec_out       = second_acc_q;
    thr_out       = third_acc_q;

    if (in_fire_i) begin
      case (op_e'(in_word_i.opcode))
        OP_CLEAR: begin
          desc_loaded_d = '0;
          desc_next_d   = '0;
          remaining_d   = '0;
          past_end_d    = 1'b0;
          cur_obj_d     = '0;
          byte_pos_d    = '0;
          type_acc_d    = '0;
          second_acc_d  = '0;
          third_acc_d   = '0;
        end
        OP_DESC: begin
          if (desc_loaded_q < CW'(MAX_SUBSECTIONS)) begin
            desc_we_o     = 1'b1;
            desc_loaded_d = desc_loaded_q + CW'(1);
          end
        end
        OP_DATA: begin
          if ((rec_len != '0) && (rec_len <= LEN_W'(MAX_RECORD_BYTES))) begin
            if (pos_ext < t1) begin
              type_acc_d = {type_acc_q[23:0], in_word_i.data_byte};
            end else if (pos_ext < t2) begin
              second_acc_d = {second_acc_q[23:0], in_word_i.data_byte};
            end else if (pos_ext < t3) begin
              third_acc_d = {third_acc_q[23:0], in_word_i.data_byte};
            end
            if (pos_nxt < rec_len) begin
              byte_pos_d = pos_nxt[PW-1:0];
            end else begin
              do_load = (remaining_q == '0) && !past_end_q && (desc_next_q < desc_loaded_q);
              if (do_load) begin
                obj         = {1'b0, desc_rd_i.start};
                rem         = desc_rd_i.count;
                desc_next_d = desc_next_q + CW'(1);
              end
              rec_type   = (width_type_q == '0) ? TYPE_PLAIN : type_acc_d;
              out_push_o = (rec_type == TYPE_PLAIN) || (rec_type == TYPE_PACKED);
              sec_out    = second_acc_d;
              thr_out    = third_acc_d;
              cur_obj_d  = obj + 32'd1;
              if (rem == '0) begin
                past_end_d  = 1'b1;
                remaining_d = '0;
              end else begin
                remaining_d = rem - 31'd1;
              end
              byte_pos_d   = '0;
              type_acc_d   = '0;
              second_acc_d = '0;
              third_acc_d  = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_word_o.entry_kind    = (rec_type == TYPE_PACKED);
    out_word_o.object_number = obj;
    out_word_o.second_value  = sec_out;
    out_word_o.third_value   = thr_out;
    desc_wdata_o.start       = in_word_i.sub_start;
    desc_wdata_o.count       = in_word_i.sub_count;
  end

  // the RAM is read at the next-state read pointer, so the descriptor at the next read pointer is fetched ahead of use
  assign desc_waddr_o = desc_loaded_q[AW-1:0];
  assign desc_raddr_o = desc_next_d[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_loaded_q <= '0;
      desc_next_q   <= '0;
      remaining_q   <= '0;
      past_end_q    <= 1'b0;
      cur_obj_q     <= '0;
      byte_pos_q    <= '0;
      type_acc_q    <= '0;
      second_acc_q  <= '0;
      third_acc_q   <= '0;
    end else begin
      desc_loaded_q <= desc_loaded_d;
      desc_next_q   <= desc_next_d;
      remaining_q   <= remaining_d;
      past_end_q    <= past_end_d;
      cur_obj_q     <= cur_obj_d;
      byte_pos_q    <= byte_pos_d;
      type_acc_q    <= type_acc_d;
      second_acc_q  <= second_acc_d;
      third_acc_q   <= third_acc_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_next_le_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_next_q <= desc_loaded_q)
    else $error("descriptor read pointer passed the write pointer");
  a_past_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    past_end_q |-> (remaining_q == '0))
    else $error("count left after the last subsection ended");
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LEN_W'(byte_pos_q) < LEN_W'(MAX_RECORD_BYTES))
    else $error("byte position beyond the longest record");
  a_load_only_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_load |-> (desc_loaded_q != '0))
    else $error("descriptor taken from an empty table");
`endif

endmodule

// ===== sv/xsrd_out_buf.sv =====
module xsrd_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  xsrd_pkg::out_word_t word_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                ready_i,
  output xsrd_pkg::out_word_t word_o
);
  import xsrd_pkg::*;

  out_word_t  buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign pop     = valid_o && ready_i;
  assign word_o  = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wp_q] <= word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("word written into a full output buffer");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("output buffer count out of range");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (wp_q != rp_q))
    else $error("output buffer pointers disagree with count");
`endif

endmodule

// ===== sv/xref_stream_record_decoder_core.sv =====
// Cross-reference stream record decoder. Accepts one word per clock while in_ready_o
// is high: descriptor words, stream bytes and clear words. A completed type 1 or
// type 2 record is pushed into the output buffer when its last byte is taken.
// Subsection descriptors sit in a single-port-write RAM of MAX_SUBSECTIONS entries
// whose next entry is prefetched (with forwarding when the entry being read is
// written the same cycle), so the object number is ready when a record closes. A
// two-word output buffer keeps input flowing while one result waits; in_ready_o
// drops only when both buffer slots are occupied. The user must write field widths
// through the cfg port only while the block is idle; the block does not enforce it.
module xref_stream_record_decoder_core #(
  parameter int unsigned MAX_RECORD_BYTES = xsrd_pkg::DEF_MAX_RECORD_BYTES,
  parameter int unsigned MAX_SUBSECTIONS  = xsrd_pkg::DEF_MAX_SUBSECTIONS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [xsrd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [xsrd_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  xsrd_pkg::in_word_t             in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output xsrd_pkg::out_word_t            out_word_o
);
  import xsrd_pkg::*;

  localparam int unsigned AW = (MAX_SUBSECTIONS > 1) ? $clog2(MAX_SUBSECTIONS) : 1;

  logic      in_fire;
  logic      buf_full;
  logic      desc_we;
  logic [AW-1:0] desc_waddr, desc_raddr;
  desc_t     desc_wdata, desc_rdata;
  logic      out_push;
  out_word_t out_word;

  assign in_ready_o = !buf_full;
  assign in_fire    = in_valid_i && in_ready_o;

  xsrd_desc_mem #(
    .DEPTH (MAX_SUBSECTIONS),
    .AW    (AW)
  ) u_desc_mem (
    .clk_i   (clk_i),
    .we_i    (desc_we),
    .waddr_i (desc_waddr),
    .wdata_i (desc_wdata),
    .raddr_i (desc_raddr),
    .rdata_o (desc_rdata)
  );

  xsrd_rec_ctrl #(
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES),
    .MAX_SUBSECTIONS  (MAX_SUBSECTIONS),
    .AW               (AW)
  ) u_rec_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_fire_i    (in_fire),
    .in_word_i    (in_word_i),
    .desc_rd_i    (desc_rdata),
    .desc_we_o    (desc_we),
    .desc_waddr_o (desc_waddr),
    .desc_wdata_o (desc_wdata),
    .desc_raddr_o (desc_raddr),
    .out_push_o   (out_push),
    .out_word_o   (out_word)
  );

  xsrd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .word_i  (out_word),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .word_o  (out_word_o)
  );

endmodule
